@@ rtl/slbr_pkg.sv @@
// shared types and constants for the scrolling led burst renderer
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
package slbr_pkg;

	// widest strip index the parameter range allows (64 leds)
	localparam int IDX_W = 6;
	localparam int LEVEL_W = 15;
	localparam int FULL_LEVEL = 16384;
	localparam logic [15:0] PERIOD_RESET = 16'd20;

	// register index, taken from the word address
	localparam logic REG_PERIOD = 1'b0;

	typedef enum logic [1:0] {
		FUNC_TICK   = 2'd0,
		FUNC_SCROLL = 2'd1,
		FUNC_CENTER = 2'd2
	} func_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_LEFT,
		BK_RIGHT
	} back_state_t;

	// one render job: up to two bursts, left first
	typedef struct packed {
		logic             l_on;
		logic [IDX_W-1:0] l_ctr;
		logic             r_on;
		logic [IDX_W-1:0] r_ctr;
	} job_t;

endpackage

@@ rtl/slbr_front.sv @@
// front part: takes requests, keeps centers, scroll flags and the scroll timer,
// and hands render jobs to the queue; depends on slbr_pkg
`timescale 1ns / 1ps
module slbr_front #(
	parameter int STRIP_LEDS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [15:0]          period,
	input  logic                 accept,
	input  logic [1:0]           func,
	input  logic                 side,
	input  logic                 dir,
	input  logic signed [5:0]    index,
	output slbr_pkg::job_t       job,
	output logic                 job_wr
);
	import slbr_pkg::*;

	// centers hold any signed index, or run from -1 to one past the strip when scrolling
	localparam int CW = (($clog2(STRIP_LEDS + 1) > 6) ? $clog2(STRIP_LEDS + 1) : 6) + 1;
	localparam logic signed [CW-1:0] NLEDS = CW'(STRIP_LEDS);
	localparam logic signed [CW-1:0] LAST_LED = CW'(STRIP_LEDS - 1);
	localparam logic signed [CW-1:0] ONE = CW'(1);

	logic signed [CW-1:0] ctr_l_q, ctr_r_q, ctr_l_d, ctr_r_d, idx_ext;
	logic mov_l_q, mov_r_q, mov_l_d, mov_r_d;
	logic up_l_q, up_r_q, up_l_d, up_r_d;
	logic [15:0] elapsed_q, elapsed_d, el_inc;

	function automatic logic on_strip(logic signed [CW-1:0] c);
		return (c >= 0) && (c < NLEDS);
	endfunction

	assign idx_ext = CW'(index);
	assign el_inc = (elapsed_q == 16'hFFFF) ? elapsed_q : elapsed_q + 16'd1;

	always_comb begin
		ctr_l_d = ctr_l_q;
		ctr_r_d = ctr_r_q;
		mov_l_d = mov_l_q;
		mov_r_d = mov_r_q;
		up_l_d = up_l_q;
		up_r_d = up_r_q;
		elapsed_d = elapsed_q;
		job = '0;
		job_wr = 1'b0;
		if (accept) begin
			case (func_t'(func))
				FUNC_TICK: begin
					// bursts go out with the centers from before the scroll step
					job.l_on = on_strip(ctr_l_q);
					job.l_ctr = ctr_l_q[IDX_W-1:0];
					job.r_on = on_strip(ctr_r_q);
					job.r_ctr = ctr_r_q[IDX_W-1:0];
					job_wr = job.l_on | job.r_on;
					elapsed_d = el_inc;
					if ((mov_l_q || mov_r_q) && (el_inc > period)) begin
						elapsed_d = '0;
						if (mov_l_q) begin
							ctr_l_d = up_l_q ? ctr_l_q + ONE : ctr_l_q - ONE;
							mov_l_d = on_strip(ctr_l_d);
						end
						if (mov_r_q) begin
							ctr_r_d = up_r_q ? ctr_r_q + ONE : ctr_r_q - ONE;
							mov_r_d = on_strip(ctr_r_d);
						end
					end
				end
				FUNC_SCROLL: begin
					if (side) begin
						up_r_d = dir;
						mov_r_d = 1'b1;
						if (ctr_r_q >= NLEDS) begin
							ctr_r_d = '0;
						end else if (ctr_r_q < 0) begin
							ctr_r_d = LAST_LED;
						end
					end else begin
						up_l_d = dir;
						mov_l_d = 1'b1;
						if (ctr_l_q >= NLEDS) begin
							ctr_l_d = '0;
						end else if (ctr_l_q < 0) begin
							ctr_l_d = LAST_LED;
						end
					end
				end
				FUNC_CENTER: begin
					if (side) begin
						ctr_r_d = idx_ext;
						job.r_on = on_strip(idx_ext);
						job.r_ctr = idx_ext[IDX_W-1:0];
						job_wr = job.r_on;
					end else begin
						ctr_l_d = idx_ext;
						job.l_on = on_strip(idx_ext);
						job.l_ctr = idx_ext[IDX_W-1:0];
						job_wr = job.l_on;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctr_l_q <= -ONE;
			ctr_r_q <= -ONE;
			mov_l_q <= 1'b0;
			mov_r_q <= 1'b0;
			up_l_q <= 1'b0;
			up_r_q <= 1'b0;
			elapsed_q <= '0;
		end else begin
			ctr_l_q <= ctr_l_d;
			ctr_r_q <= ctr_r_d;
			mov_l_q <= mov_l_d;
			mov_r_q <= mov_r_d;
			up_l_q <= up_l_d;
			up_r_q <= up_r_d;
			elapsed_q <= elapsed_d;
		end
	end

endmodule

@@ rtl/slbr_fifo.sv @@
// short job queue between the front and back parts
// depends on slbr_pkg for the job type
`timescale 1ns / 1ps
module slbr_fifo #(
	parameter int DEPTH = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr,
	input  slbr_pkg::job_t wdata,
	input  logic           rd,
	output slbr_pkg::job_t rdata,
	output logic           full,
	output logic           empty
);
	import slbr_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	job_t mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [NW-1:0] count_q;

	function automatic logic [AW-1:0] next_ptr(logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	assign full = (count_q == NW'(DEPTH));
	assign empty = (count_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (rd) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			count_q <= count_q + NW'(wr) - NW'(rd);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) wr |-> !full)
		else $error("job written into a full queue");
	assert property (@(posedge clk) disable iff (!arst_n) rd |-> !empty)
		else $error("job read from an empty queue");
	assert property (@(posedge clk) disable iff (!arst_n) count_q <= NW'(DEPTH))
		else $error("queue fill count out of range");

endmodule

@@ rtl/slbr_back.sv @@
// back part: walks each queued burst led by led and fills the result register
// depends on slbr_pkg
`timescale 1ns / 1ps
module slbr_back #(
	parameter int STRIP_LEDS = 16,
	parameter int BURST_SPAN = 5
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  slbr_pkg::job_t                 head,
	input  logic                           head_valid,
	output logic                           head_rd,
	output logic                           out_valid,
	input  logic                           pop,
	output logic                           strip,
	output logic [3:0]                     led,
	output logic [slbr_pkg::LEVEL_W-1:0]   level,
	output logic                           last
);
	import slbr_pkg::*;

	localparam int HALF = BURST_SPAN / 2;
	localparam int DW = (HALF > 0) ? $clog2(HALF + 1) : 1;
	localparam logic [IDX_W:0] HALF_X = (IDX_W + 1)'(HALF);
	localparam logic [IDX_W:0] LAST_X = (IDX_W + 1)'(STRIP_LEDS - 1);

	logic [LEVEL_W-1:0] lvl_tab [HALF + 1];

	for (genvar g = 0; g <= HALF; g++) begin : g_lvl
		localparam int unsigned LV = (FULL_LEVEL * (HALF + 1 - g)) / (HALF + 1);
		assign lvl_tab[g] = LEVEL_W'(LV);
	end

	back_state_t state_q, state_d;
	job_t job_q;
	logic [IDX_W-1:0] pos_q, end_q, ctr_q, ld_ctr, diff;
	logic [DW-1:0] lvl_sel;
	logic ld, emit, adv, fin_side;
	logic out_valid_q, strip_q, last_q;
	logic [3:0] led_q;
	logic [LEVEL_W-1:0] level_q;

	// first and last lit led of a burst, clipped to the strip
	function automatic logic [IDX_W-1:0] lo_of(logic [IDX_W-1:0] c);
		return (c >= HALF_X[IDX_W-1:0]) ? c - HALF_X[IDX_W-1:0] : '0;
	endfunction

	function automatic logic [IDX_W-1:0] hi_of(logic [IDX_W-1:0] c);
		logic [IDX_W:0] s;
		s = {1'b0, c} + HALF_X;
		return (s > LAST_X) ? LAST_X[IDX_W-1:0] : s[IDX_W-1:0];
	endfunction

	assign adv = !out_valid_q || pop;
	assign fin_side = (pos_q == end_q);
	assign diff = (pos_q >= ctr_q) ? pos_q - ctr_q : ctr_q - pos_q;
	assign lvl_sel = diff[DW-1:0];

	always_comb begin
		state_d = state_q;
		head_rd = 1'b0;
		ld = 1'b0;
		ld_ctr = '0;
		emit = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (head_valid) begin
					head_rd = 1'b1;
					ld = 1'b1;
					if (head.l_on) begin
						state_d = BK_LEFT;
						ld_ctr = head.l_ctr;
					end else begin
						state_d = BK_RIGHT;
						ld_ctr = head.r_ctr;
					end
				end
			end
			BK_LEFT: begin
				if (adv) begin
					emit = 1'b1;
					if (fin_side) begin
						if (job_q.r_on) begin
							state_d = BK_RIGHT;
							ld = 1'b1;
							ld_ctr = job_q.r_ctr;
						end else begin
							state_d = BK_IDLE;
						end
					end
				end
			end
			BK_RIGHT: begin
				if (adv) begin
					emit = 1'b1;
					if (fin_side) begin
						state_d = BK_IDLE;
					end
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (head_rd) begin
			job_q <= head;
		end
		if (ld) begin
			ctr_q <= ld_ctr;
			pos_q <= lo_of(ld_ctr);
			end_q <= hi_of(ld_ctr);
		end else if (emit) begin
			pos_q <= pos_q + IDX_W'(1);
		end
		if (emit) begin
			strip_q <= (state_q == BK_RIGHT);
			led_q <= pos_q[3:0];
			level_q <= lvl_tab[lvl_sel];
			// final value of the request: end of the right burst, or of a lone left one
			last_q <= fin_side && ((state_q == BK_RIGHT) || !job_q.r_on);
		end
	end

	assign out_valid = out_valid_q;
	assign strip = strip_q;
	assign led = led_q;
	assign level = level_q;
	assign last = last_q;

	assert property (@(posedge clk) disable iff (!arst_n) head_rd |-> (head.l_on || head.r_on))
		else $error("queued job lights nothing");
	assert property (@(posedge clk) disable iff (!arst_n) (state_q == BK_LEFT) |-> job_q.l_on)
		else $error("walking a left burst that is off strip");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_LEFT || state_q == BK_RIGHT) |-> (pos_q <= end_q))
		else $error("led walk ran past its end");
	assert property (@(posedge clk) disable iff (!arst_n) (out_valid_q && !pop) |=> out_valid_q)
		else $error("waiting result dropped");

endmodule

@@ rtl/scrolling_led_burst_renderer_top.sv @@
// channel   | handshake              | payload
// config    | psel/penable/pwrite    | paddr, pwdata, prdata (scroll_period_ms)
// request   | push, full             | func, side, dir, index
// result    | pop, empty             | strip, led, level, last
//
// a request is taken whenever the job queue has room; requests that
// light nothing leave no trace downstream
// a queued job is loaded from the idle state, then its lit leds are walked in turn, the right
// burst loaded as the left one ends; each led waits while the last result is not yet popped
// the led walk in the back part sets the rate; the job queue lets the front keep
// taking requests while results wait on pop
// reset clears centers to off strip, scrolling state, the timer, the queue and the result,
// and sets the period to its default; depends on slbr_pkg, slbr_front, slbr_fifo, slbr_back
`timescale 1ns / 1ps
module scrolling_led_burst_renderer_top #(
	parameter int STRIP_LEDS = 16,
	parameter int BURST_SPAN = 5,
	parameter int JOB_DEPTH = 2
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [2:0]                   paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	input  logic                         push,
	output logic                         full,
	input  logic [1:0]                   func,
	input  logic                         side,
	input  logic                         dir,
	input  logic signed [5:0]            index,
	output logic                         empty,
	input  logic                         pop,
	output logic                         strip,
	output logic [3:0]                   led,
	output logic [slbr_pkg::LEVEL_W-1:0] level,
	output logic                         last
);
	import slbr_pkg::*;

	logic [15:0] period_q;
	logic accept, job_wr, head_valid, head_rd, q_empty, out_valid;
	job_t job, head;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_PERIOD) ? {16'b0, period_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RESET;
		end else if (psel && penable && pwrite && (paddr[2] == REG_PERIOD)) begin
			period_q <= pwdata[15:0];
		end
	end

	assign accept = push && !full;

	slbr_front #(
		.STRIP_LEDS(STRIP_LEDS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.period(period_q),
		.accept(accept),
		.func(func),
		.side(side),
		.dir(dir),
		.index(index),
		.job(job),
		.job_wr(job_wr)
	);

	slbr_fifo #(
		.DEPTH(JOB_DEPTH)
	) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.wr(job_wr),
		.wdata(job),
		.rd(head_rd),
		.rdata(head),
		.full(full),
		.empty(q_empty)
	);

	assign head_valid = !q_empty;

	slbr_back #(
		.STRIP_LEDS(STRIP_LEDS),
		.BURST_SPAN(BURST_SPAN)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.head_valid(head_valid),
		.head_rd(head_rd),
		.out_valid(out_valid),
		.pop(pop),
		.strip(strip),
		.led(led),
		.level(level),
		.last(last)
	);

	assign empty = !out_valid;

endmodule
